FILE: sv/mdc_pkg.sv
// shared types, codes and helpers for the mosi directory controller
package mdc_pkg;

    localparam int NODE_COUNT  = 16;
    localparam int NODE_W      = 4;
    localparam int OWN_W       = 5;
    localparam int BLOCK_COUNT = 1024;
    localparam int BLK_W       = 10;
    localparam int LAT_W       = 10;
    localparam int CNT_W       = 5;

    localparam logic [3:0] ST_I  = 4'd0;
    localparam logic [3:0] ST_S  = 4'd1;
    localparam logic [3:0] ST_M  = 4'd2;
    localparam logic [3:0] ST_O  = 4'd3;
    localparam logic [3:0] ST_MM = 4'd4;
    localparam logic [3:0] ST_MO = 4'd5;
    localparam logic [3:0] ST_SM = 4'd6;
    localparam logic [3:0] ST_OM = 4'd7;
    localparam logic [3:0] ST_OO = 4'd8;

    localparam logic [2:0] A_GETS   = 3'd1;
    localparam logic [2:0] A_GETM   = 3'd2;
    localparam logic [2:0] A_DATA   = 3'd3;
    localparam logic [2:0] A_INVACK = 3'd4;

    localparam logic [2:0] K_DATA = 3'd0;
    localparam logic [2:0] K_ACK  = 3'd1;
    localparam logic [2:0] K_INV  = 3'd2;
    localparam logic [2:0] K_RGS  = 3'd3;
    localparam logic [2:0] K_RGI  = 3'd4;

    localparam logic [2:0] D_IDLE      = 3'd0;
    localparam logic [2:0] D_OK        = 3'd1;
    localparam logic [2:0] D_REQUEUE   = 3'd2;
    localparam logic [2:0] D_BUSY      = 3'd3;
    localparam logic [2:0] D_BADPAIR   = 3'd4;
    localparam logic [2:0] D_EXCESS    = 3'd5;
    localparam logic [2:0] D_OWNERGETS = 3'd6;

    typedef struct packed {
        logic [3:0]            state;
        logic [NODE_COUNT-1:0] pres;
        logic [OWN_W-1:0]      owner;
        logic [NODE_W-1:0]     req;
        logic [CNT_W-1:0]      acks;
        logic [CNT_W-1:0]      shc;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [BLK_W-1:0] addr;
        entry_t           data;
    } dir_wr_t;

    typedef struct packed {
        logic              memrd;
        logic              c2c;
        logic [2:0]        kind;
        logic [BLK_W-1:0]  blk;
        logic [NODE_W-1:0] dest;
    } msg_t;

    localparam entry_t ENTRY_RST = '{state: ST_I, pres: '0, owner: OWN_W'(NODE_COUNT),
                                     req: '0, acks: '0, shc: '0};

    function automatic logic [CNT_W-1:0] inc5(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] dec5(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    function automatic logic [NODE_W-1:0] dest_of(input logic [OWN_W-1:0] n);
        return (n < OWN_W'(NODE_COUNT)) ? n[NODE_W-1:0] : '1;
    endfunction

endpackage

FILE: sv/mdc_dir.sv
// directory entry store with clearing sweep after reset
module mdc_dir
    import mdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [BLK_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  dir_wr_t          wr,
    output logic             clr_done
);

    entry_t         mem [BLOCK_COUNT];
    logic [BLK_W:0] clr_reg;
    entry_t         rd_data_reg;

    assign clr_done = clr_reg[BLK_W];
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (!clr_done)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_done)
        begin
            mem[clr_reg[BLK_W-1:0]] <= ENTRY_RST;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_wr_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> clr_done)
        else $error("directory write during clearing sweep");

endmodule

FILE: sv/mosi_directory_controller_core.sv
// mosi directory controller: request sequencer, invalidation scan and memory read timer
// latency: a request passes the exec state, optionally the scan and fin states, then
// the mem and flush states; its last result is registered on leaving flush
// throughput: one request at a time; a new one is taken only back in idle, and
// output back-pressure stalls the scan, fin, mem and flush states
// reset: a sweep clears all 1024 directory entries before the first request
module mosi_directory_controller_core
    import mdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [LAT_W-1:0] cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // action, source_node, block_index
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // message_valid, message_dest, message_block,
                                             // message_kind, cache_transfer, memory_read
    output logic [2:0]       m_axis_tuser,   // disposition
    output logic             m_axis_tlast
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_MEM   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]        seq_reg, seq_next;
    logic [LAT_W-1:0]  lat_reg;
    logic [CNT_W-1:0]  nodes_reg;
    logic [2:0]        act_reg;
    logic [NODE_W-1:0] src_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [2:0]        disp_reg, disp_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [OWN_W-1:0]  tgt_reg, tgt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              pend_valid_reg;
    msg_t              pend_reg;
    logic              out_valid_reg, out_mv_reg, out_last_reg;
    msg_t              out_msg_reg;
    logic [2:0]        out_disp_reg;
    logic              mem_busy_reg;
    logic [LAT_W-1:0]  mem_cnt_reg;
    logic [BLK_W-1:0]  mem_blk_reg;
    logic [NODE_W-1:0] mem_tgt_reg;

    entry_t            e, ent_n;
    dir_wr_t           wr;
    logic              clr_done, accept, out_free, go;
    logic              emit, start, push, push_last, mem_done, mem_dec;
    msg_t              msg;
    logic [NODE_W-1:0] start_tgt;
    logic [CNT_W-1:0]  lim;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (seq_reg == S_IDLE) && clr_done;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign lim      = (nodes_reg > CNT_W'(NODE_COUNT)) ? CNT_W'(NODE_COUNT) : nodes_reg;

    mdc_dir u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (s_axis_tdata[16:7]),
        .rd_data  (e),
        .wr       (wr),
        .clr_done (clr_done)
    );

    always_comb
    begin
        logic gets, getm, data, inva, trans;
        logic [NODE_COUNT-1:0] p1;
        logic [CNT_W-1:0] a1, s1;
        gets  = act_reg == A_GETS;
        getm  = act_reg == A_GETM;
        data  = act_reg == A_DATA;
        inva  = act_reg == A_INVACK;
        trans = e.state == ST_SM || e.state == ST_MM || e.state == ST_MO ||
                e.state == ST_OM || e.state == ST_OO;
        p1 = e.pres;
        a1 = e.acks;
        s1 = e.shc;
        seq_next  = seq_reg;
        disp_next = disp_reg;
        idx_next  = idx_reg;
        tgt_next  = tgt_reg;
        n_next    = n_reg;
        ent_n     = e;
        wr        = '{en: 1'b0, addr: blk_reg, data: e};
        emit      = 1'b0;
        msg       = '{memrd: 1'b0, c2c: 1'b0, kind: K_DATA, blk: blk_reg, dest: '0};
        start     = 1'b0;
        start_tgt = src_reg;
        push      = 1'b0;
        push_last = 1'b0;
        mem_done  = 1'b0;
        mem_dec   = 1'b0;
        go        = 1'b0;
        unique case (seq_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    seq_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                go        = 1'b1;
                seq_next  = S_MEM;
                disp_next = D_OK;
                idx_next  = '0;
                tgt_next  = OWN_W'(NODE_COUNT);
                n_next    = '0;
                if (!(gets || getm || data || inva))
                begin
                    disp_next = D_IDLE;
                end
                else if (mem_busy_reg)
                begin
                    disp_next = D_BUSY;
                end
                else if (e.state == ST_I && (gets || getm))
                begin
                    start       = 1'b1;
                    ent_n.state = getm ? ST_M : ST_S;
                    ent_n.pres  = e.pres | (NODE_COUNT'(1) << src_reg);
                    ent_n.shc   = inc5(e.shc);
                    wr.en       = 1'b1;
                end
                else if (e.state == ST_S && gets)
                begin
                    start      = 1'b1;
                    ent_n.pres = e.pres | (NODE_COUNT'(1) << src_reg);
                    ent_n.shc  = inc5(e.shc);
                    wr.en      = 1'b1;
                end
                else if (e.state == ST_M && (gets || getm))
                begin
                    seq_next = S_SCAN;
                end
                else if ((e.state == ST_MO || e.state == ST_OO) && data)
                begin
                    emit        = 1'b1;
                    msg.dest    = e.req;
                    msg.c2c     = 1'b1;
                    ent_n.state = ST_O;
                    ent_n.pres  = e.pres | (NODE_COUNT'(1) << e.req);
                    ent_n.shc   = inc5(e.shc);
                    wr.en       = 1'b1;
                end
                else if (e.state == ST_MM && data)
                begin
                    emit        = 1'b1;
                    msg.dest    = e.req;
                    msg.c2c     = 1'b1;
                    ent_n.state = ST_M;
                    ent_n.pres  = (e.pres & ~(NODE_COUNT'(1) << src_reg)) |
                                  (NODE_COUNT'(1) << e.req);
                    ent_n.shc   = inc5(dec5(e.shc));
                    wr.en       = 1'b1;
                end
                else if ((e.state == ST_S || e.state == ST_O) && getm)
                begin
                    seq_next = S_SCAN;
                end
                else if (e.state == ST_O && gets)
                begin
                    if (e.owner == {1'b0, src_reg})
                    begin
                        disp_next = D_OWNERGETS;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        msg.dest    = dest_of(e.owner);
                        msg.kind    = K_RGS;
                        ent_n.req   = src_reg;
                        ent_n.state = ST_OO;
                        wr.en       = 1'b1;
                    end
                end
                else if ((e.state == ST_SM || e.state == ST_OM) && inva)
                begin
                    if (e.acks == '0)
                    begin
                        disp_next = D_EXCESS;
                    end
                    else
                    begin
                        p1    = e.pres & ~(NODE_COUNT'(1) << src_reg);
                        a1    = e.acks - 1'b1;
                        s1    = dec5(e.shc);
                        wr.en = 1'b1;
                        if (a1 == '0)
                        begin
                            if (e.state == ST_SM)
                            begin
                                if (p1[e.req])
                                begin
                                    emit     = 1'b1;
                                    msg.dest = e.req;
                                    msg.kind = K_ACK;
                                end
                                else
                                begin
                                    start     = 1'b1;
                                    start_tgt = e.req;
                                    p1        = p1 | (NODE_COUNT'(1) << e.req);
                                    s1        = inc5(s1);
                                end
                                ent_n.state = ST_M;
                            end
                            else if (s1 == CNT_W'(1) && {1'b0, e.req} == e.owner)
                            begin
                                emit        = 1'b1;
                                msg.dest    = e.req;
                                msg.kind    = K_ACK;
                                ent_n.state = ST_M;
                            end
                            else
                            begin
                                emit     = 1'b1;
                                msg.dest = dest_of(e.owner);
                                msg.kind = K_RGI;
                            end
                        end
                        ent_n.pres = p1;
                        ent_n.acks = a1;
                        ent_n.shc  = s1;
                    end
                end
                else if (e.state == ST_OM && data)
                begin
                    if (e.owner < OWN_W'(NODE_COUNT))
                    begin
                        p1 = e.pres & ~(NODE_COUNT'(1) << e.owner[NODE_W-1:0]);
                    end
                    s1       = dec5(e.shc);
                    emit     = 1'b1;
                    msg.dest = e.req;
                    msg.c2c  = 1'b1;
                    if (p1[e.req])
                    begin
                        msg.kind = K_ACK;
                    end
                    else
                    begin
                        p1 = p1 | (NODE_COUNT'(1) << e.req);
                        s1 = inc5(s1);
                    end
                    ent_n.pres  = p1;
                    ent_n.shc   = s1;
                    ent_n.owner = OWN_W'(NODE_COUNT);
                    ent_n.state = ST_M;
                    wr.en       = 1'b1;
                end
                else if (trans && (gets || getm))
                begin
                    disp_next = D_REQUEUE;
                end
                else
                begin
                    disp_next = D_BADPAIR;
                end
            end
            S_SCAN:
            begin
                go = out_free;
                if (go)
                begin
                    if (idx_reg >= lim)
                    begin
                        seq_next = S_FIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (e.state == ST_M)
                        begin
                            if (e.pres[idx_reg[NODE_W-1:0]])
                            begin
                                tgt_next = idx_reg;
                            end
                        end
                        else if (e.pres[idx_reg[NODE_W-1:0]] &&
                                 idx_reg != {1'b0, src_reg} &&
                                 (e.state == ST_S || idx_reg != e.owner))
                        begin
                            n_next   = inc5(n_reg);
                            emit     = 1'b1;
                            msg.dest = idx_reg[NODE_W-1:0];
                            msg.kind = K_INV;
                        end
                    end
                end
            end
            S_FIN:
            begin
                go = out_free;
                if (go)
                begin
                    seq_next = S_MEM;
                    wr.en    = 1'b1;
                    if (e.state == ST_M)
                    begin
                        if (gets && tgt_reg < OWN_W'(NODE_COUNT))
                        begin
                            ent_n.owner = tgt_reg;
                        end
                        emit        = 1'b1;
                        msg.dest    = dest_of(tgt_reg);
                        msg.kind    = gets ? K_RGS : K_RGI;
                        ent_n.state = gets ? ST_MO : ST_MM;
                        ent_n.req   = src_reg;
                    end
                    else
                    begin
                        ent_n.acks = n_reg;
                        if (e.state == ST_S)
                        begin
                            if (n_reg == '0)
                            begin
                                emit        = 1'b1;
                                msg.dest    = src_reg;
                                msg.kind    = K_ACK;
                                ent_n.state = ST_M;
                            end
                            else
                            begin
                                ent_n.state = ST_SM;
                                ent_n.req   = src_reg;
                            end
                        end
                        else
                        begin
                            if (n_reg == '0)
                            begin
                                emit     = 1'b1;
                                msg.dest = dest_of(e.owner);
                                msg.kind = K_RGI;
                            end
                            ent_n.req   = src_reg;
                            ent_n.state = ST_OM;
                        end
                    end
                end
            end
            S_MEM:
            begin
                go = out_free;
                if (go)
                begin
                    seq_next = S_FLUSH;
                    if (mem_busy_reg)
                    begin
                        if (mem_cnt_reg == '0)
                        begin
                            mem_done  = 1'b1;
                            emit      = 1'b1;
                            msg.dest  = mem_tgt_reg;
                            msg.blk   = mem_blk_reg;
                            msg.memrd = 1'b1;
                        end
                        else
                        begin
                            mem_dec = 1'b1;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                go = out_free;
                if (go)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    seq_next  = S_IDLE;
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
        wr.data = ent_n;
        if (emit && pend_valid_reg)
        begin
            push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= S_IDLE;
            lat_reg        <= LAT_W'(100);
            nodes_reg      <= CNT_W'(NODE_COUNT);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            mem_busy_reg   <= 1'b0;
            mem_cnt_reg    <= '0;
            mem_blk_reg    <= '0;
            mem_tgt_reg    <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (cfg_wr_en)
            begin
                if (cfg_index)
                begin
                    nodes_reg <= cfg_data[CNT_W-1:0];
                end
                else
                begin
                    lat_reg <= cfg_data;
                end
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (push_last)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (start)
            begin
                mem_busy_reg <= 1'b1;
                mem_cnt_reg  <= lat_reg;
                mem_blk_reg  <= blk_reg;
                mem_tgt_reg  <= start_tgt;
            end
            else if (mem_done)
            begin
                mem_busy_reg <= 1'b0;
            end
            else if (mem_dec)
            begin
                mem_cnt_reg <= mem_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= s_axis_tdata[2:0];
            src_reg <= s_axis_tdata[6:3];
            blk_reg <= s_axis_tdata[16:7];
        end
        disp_reg <= disp_next;
        idx_reg  <= idx_next;
        tgt_reg  <= tgt_next;
        n_reg    <= n_next;
        if (emit)
        begin
            pend_reg <= msg;
        end
        if (push)
        begin
            out_msg_reg  <= pend_valid_reg ? pend_reg : '0;
            out_mv_reg   <= pend_valid_reg;
            out_disp_reg <= disp_reg;
            out_last_reg <= push_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_msg_reg.memrd, out_msg_reg.c2c, out_msg_reg.kind,
                            out_msg_reg.blk, out_msg_reg.dest, out_mv_reg};
    assign m_axis_tuser  = out_disp_reg;
    assign m_axis_tlast  = out_last_reg;

    a_exec_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == S_EXEC) |-> !pend_valid_reg)
        else $error("pending message left over from previous request");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (seq_reg == S_EXEC))
        else $error("accepted request did not enter execution");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == S_FLUSH && out_free) |=> (out_valid_reg && out_last_reg))
        else $error("final result not marked last");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == S_SCAN) |-> (idx_reg <= CNT_W'(NODE_COUNT)))
        else $error("scan index ran past node count");

endmodule
